// ===== sv/median_adaptive_ema_filter_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the median / adaptive EMA filter core
// Concurrent property wrappers clocked on i_clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_ADAPTIVE_EMA_FILTER_CORE_ASSERT_SVH
`define MEDIAN_ADAPTIVE_EMA_FILTER_CORE_ASSERT_SVH

// same-cycle implication
`define MAE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define MAE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/mae_pkg.sv =====
// ----------------------------------------------------------------------------
// mae_pkg
// Shared types and constants of the median / adaptive EMA filter core.
// ----------------------------------------------------------------------------
package mae_pkg;

    localparam int FRAC_SHIFT = 8;        // Q8.8 -> Q8.16
    localparam int GAIN_SHIFT = 16;       // Q0.16 gain
    localparam int LEVEL_MAX  = 6553600;  // 100 psi in Q8.16
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NORMAL_GAIN    = 3'd0,
        REG_FAST_GAIN      = 3'd1,
        REG_STEP_THRESHOLD = 3'd2,
        REG_LOW_THRESHOLD  = 3'd3,
        REG_HOLD_SAMPLES   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] normal_gain;
        logic [15:0] fast_gain;
        logic [14:0] step_threshold;
        logic [14:0] low_threshold;
        logic [15:0] hold_samples;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        normal_gain:    16'd6554,
        fast_gain:      16'd32768,
        step_threshold: 15'd1280,
        low_threshold:  15'd0,
        hold_samples:   16'd0
    };

endpackage

// ===== sv/mae_median3.sv =====
// ----------------------------------------------------------------------------
// mae_median3
// Median of three signed samples from a min/max network.
// ----------------------------------------------------------------------------
module mae_median3 #(
    parameter int SAMPLE_W = 16
) (
    input  logic signed [SAMPLE_W-1:0] i_a,
    input  logic signed [SAMPLE_W-1:0] i_b,
    input  logic signed [SAMPLE_W-1:0] i_c,
    output logic signed [SAMPLE_W-1:0] o_med
);

    logic signed [SAMPLE_W-1:0] w_lo;
    logic signed [SAMPLE_W-1:0] w_hi;
    logic signed [SAMPLE_W-1:0] w_hc;

    always_comb begin
        w_lo  = (i_a > i_b) ? i_b : i_a;
        w_hi  = (i_a > i_b) ? i_a : i_b;
        w_hc  = (w_hi > i_c) ? i_c : w_hi;
        o_med = (w_lo > w_hc) ? w_lo : w_hc;
    end

endmodule

// ===== sv/mae_ema_update.sv =====
// ----------------------------------------------------------------------------
// mae_ema_update
// One adaptive EMA step: low pass-through, jump detect, hold count,
// gain multiply and clamp to 0..100 psi.
// ----------------------------------------------------------------------------
module mae_ema_update import mae_pkg::*; #(
    parameter int SAMPLE_W = 16,
    parameter int LEVEL_W  = 25
) (
    input  logic signed [SAMPLE_W-1:0] i_med,
    input  logic signed [LEVEL_W-1:0]  i_level,
    input  logic [15:0]                i_hold,
    input  t_cfg                       i_cfg,
    output logic signed [LEVEL_W-1:0]  o_level,
    output logic [15:0]                o_hold
);

    localparam int CMP_W = ((SAMPLE_W > 16) ? SAMPLE_W : 16) + 1;
    localparam int DW    = LEVEL_W + 1;
    localparam int PW    = DW + 17;
    localparam int SUMW  = DW + 1;

    logic signed [CMP_W-1:0] w_med_x;
    logic signed [CMP_W-1:0] w_low_x;
    logic                    w_low_pass;
    logic signed [DW-1:0]    w_med_q;
    logic signed [DW-1:0]    w_delta;
    logic [DW-1:0]           w_mag;
    logic                    w_jump;
    logic [15:0]             w_hold_ld;
    logic                    w_fast;
    logic [15:0]             w_gain;
    logic signed [PW-1:0]    w_prod;
    logic signed [SUMW-1:0]  w_sum;

    always_comb begin
        w_med_x    = CMP_W'(i_med);
        w_low_x    = CMP_W'($signed({1'b0, i_cfg.low_threshold}));
        w_low_pass = (w_med_x <= w_low_x);

        w_med_q = DW'(i_med) <<< FRAC_SHIFT;
        w_delta = w_med_q - DW'(i_level);
        w_mag   = w_delta[DW-1] ? DW'(-w_delta) : DW'(w_delta);
        w_jump  = (w_mag >= DW'({i_cfg.step_threshold, 8'd0}));

        w_hold_ld = w_jump ? i_cfg.hold_samples : i_hold;
        w_fast    = (w_hold_ld != 16'd0);
        w_gain    = w_fast ? i_cfg.fast_gain : i_cfg.normal_gain;

        w_prod = PW'($signed({1'b0, w_gain})) * PW'(w_delta);
        w_sum  = SUMW'(i_level) + SUMW'(w_prod >>> GAIN_SHIFT);

        if (w_low_pass) begin
            o_level = LEVEL_W'(w_med_q);
            o_hold  = 16'd0;
        end else begin
            o_hold = w_fast ? (w_hold_ld - 16'd1) : w_hold_ld;
            if (w_sum < SUMW'(0)) begin
                o_level = '0;
            end else if (w_sum > SUMW'(LEVEL_MAX)) begin
                o_level = LEVEL_W'(LEVEL_MAX);
            end else begin
                o_level = LEVEL_W'(w_sum);
            end
        end
    end

endmodule

// ===== sv/median_adaptive_ema_filter_core.sv =====
// ----------------------------------------------------------------------------
// median_adaptive_ema_filter_core
// Median-of-three pre-filter and adaptive exponential moving average for
// signed Q8.8 pressure samples.
// ----------------------------------------------------------------------------
//  channel   dir  payload                         handshake
//  s_axis    in   tdata: sample (Q8.8, signed)    tvalid / tready
//  m_axis    out  tdata: filtered (Q8.8, signed)  tvalid / tready
//  cfg       in   index, data                     we (no wait)
//
//  One beat per cycle sustained while m_axis is not stalled; a sample passes
//  the input register, then the median/multiply/clamp step into the result
//  register that drives m_axis. The level loop closes in that single step.
//  Synchronous active-low reset clears state and restores register defaults.
//  A stalled m_axis holds the result; s_axis keeps taking beats while the
//  result register is being emptied in the same cycle.
// ----------------------------------------------------------------------------
module median_adaptive_ema_filter_core import mae_pkg::*; #(
    parameter int  SAMPLE_WIDTH = 16,
    localparam int TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  logic [TDATA_W-1:0]      i_s_axis_tdata,   // [SAMPLE_WIDTH-1:0] sample
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    output logic [TDATA_W-1:0]      o_m_axis_tdata,   // [SAMPLE_WIDTH-1:0] filtered
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int LEVEL_W = ((SAMPLE_WIDTH + 8) > 25) ? (SAMPLE_WIDTH + 8) : 25;

    `include "median_adaptive_ema_filter_core_assert.svh"

    t_cfg                          r_cfg;
    logic signed [SAMPLE_WIDTH-1:0] r_window [3];
    logic [1:0]                    r_slot;
    logic signed [LEVEL_W-1:0]     r_level;
    logic                          r_primed;
    logic [15:0]                   r_hold;
    logic                          r_in_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic                          r_out_valid;
    logic [SAMPLE_WIDTH-1:0]       r_out_data;

    logic                          w_adv;
    logic                          w_in_acc;
    logic signed [SAMPLE_WIDTH-1:0] w_win [3];
    logic signed [SAMPLE_WIDTH-1:0] w_med;
    logic signed [LEVEL_W-1:0]     w_upd_level;
    logic [15:0]                   w_upd_hold;
    logic signed [LEVEL_W-1:0]     n_level;
    logic [15:0]                   n_hold;
    logic [1:0]                    n_slot;

    always_comb begin
        w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
        o_s_axis_tready = !r_in_valid || w_adv;
        w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
        o_m_axis_tvalid = r_out_valid;
        o_m_axis_tdata  = TDATA_W'(r_out_data);
    end

    // new sample replaces the oldest entry
    always_comb begin
        w_win[0] = ((r_slot == 2'd0) || (r_slot == 2'd3)) ? r_sample : r_window[0];
        w_win[1] = (r_slot == 2'd1) ? r_sample : r_window[1];
        w_win[2] = (r_slot == 2'd2) ? r_sample : r_window[2];
    end

    mae_median3 #(
        .SAMPLE_W (SAMPLE_WIDTH)
    ) u_median (
        .i_a   (w_win[0]),
        .i_b   (w_win[1]),
        .i_c   (w_win[2]),
        .o_med (w_med)
    );

    mae_ema_update #(
        .SAMPLE_W (SAMPLE_WIDTH),
        .LEVEL_W  (LEVEL_W)
    ) u_update (
        .i_med   (w_med),
        .i_level (r_level),
        .i_hold  (r_hold),
        .i_cfg   (r_cfg),
        .o_level (w_upd_level),
        .o_hold  (w_upd_hold)
    );

    always_comb begin
        if (!r_primed) begin
            n_level = LEVEL_W'(r_sample) <<< FRAC_SHIFT;
            n_hold  = r_hold;
            n_slot  = r_slot;
        end else begin
            n_level = w_upd_level;
            n_hold  = w_upd_hold;
            n_slot  = (r_slot >= 2'd2) ? 2'd0 : (r_slot + 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CFG_RESET;
            r_window[0] <= '0;
            r_window[1] <= '0;
            r_window[2] <= '0;
            r_slot      <= 2'd0;
            r_level     <= '0;
            r_primed    <= 1'b0;
            r_hold      <= 16'd0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_NORMAL_GAIN:    r_cfg.normal_gain    <= i_cfg_data;
                    REG_FAST_GAIN:      r_cfg.fast_gain      <= i_cfg_data;
                    REG_STEP_THRESHOLD: r_cfg.step_threshold <= i_cfg_data[14:0];
                    REG_LOW_THRESHOLD:  r_cfg.low_threshold  <= i_cfg_data[14:0];
                    REG_HOLD_SAMPLES:   r_cfg.hold_samples   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_in_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_adv) begin
                // first beat fills every entry
                r_window[0] <= r_primed ? w_win[0] : r_sample;
                r_window[1] <= r_primed ? w_win[1] : r_sample;
                r_window[2] <= r_primed ? w_win[2] : r_sample;
                r_slot      <= n_slot;
                r_level     <= n_level;
                r_hold      <= n_hold;
                r_primed    <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sample <= $signed(i_s_axis_tdata[SAMPLE_WIDTH-1:0]);
        end
        if (w_adv) begin
            r_out_data <= n_level[SAMPLE_WIDTH+FRAC_SHIFT-1:FRAC_SHIFT];
        end
    end

    `MAE_ASSERT_NEXT(a_adv_fills_out, w_adv, r_out_valid)
    `MAE_ASSERT_NEXT(a_acc_fills_in, w_in_acc, r_in_valid)
    `MAE_ASSERT_NOW(a_slot_range, r_in_valid || !r_in_valid, r_slot != 2'd3)

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the median / adaptive EMA filter core. A directed
// table walks the extremes, clamp, pass-through, fast hold and register
// handling, then phased random traffic runs under several register settings.
// Results are compared against a bit-true software filter model or typed row values.
// ----------------------------------------------------------------------------
module testbench;
    import mae_pkg::*;

    localparam int SAMPLE_W   = 16;
    localparam int TDATA_BITS = ((SAMPLE_W + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 2000;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 141;

    // indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    typedef enum bit {ROW_SAMPLE, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [15:0]           value;
        bit                    typed;
        logic [SAMPLE_W-1:0]   want;
    } t_stim_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [TDATA_BITS-1:0]  i_s_axis_tdata = '0;   // [15:0] sample
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [TDATA_BITS-1:0]  o_m_axis_tdata;        // [15:0] filtered
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    median_adaptive_ema_filter_core #(
        .SAMPLE_WIDTH (SAMPLE_W)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // filter model state and register copy
    t_cfg                filt_cfg = CFG_RESET;
    longint              win_hist [3] = '{0, 0, 0};
    int unsigned         win_slot = 0;
    longint              level_q16 = 0;
    bit                  primed_q = 1'b0;
    logic [15:0]         hold_cnt = '0;

    logic [SAMPLE_W-1:0] expected_filtered [$];
    int                  mismatches = 0;
    int                  results_checked = 0;
    bit                  quiet_run = 1'b0;
    bit                  cfg_open = 1'b0;

    function automatic logic [SAMPLE_W-1:0] next_filtered(input logic signed [SAMPLE_W-1:0] s);
        longint a, b, c, t, delta, mag, gain;
        if (!primed_q) begin
            win_hist = '{longint'(s), longint'(s), longint'(s)};
            level_q16 = longint'(s) <<< FRAC_SHIFT;
            primed_q = 1'b1;
            return s;
        end
        win_hist[win_slot] = longint'(s);
        win_slot = (win_slot == 2) ? 0 : win_slot + 1;

        a = win_hist[0];
        b = win_hist[1];
        c = win_hist[2];
        if (a > b) begin t = a; a = b; b = t; end
        if (b > c) begin t = b; b = c; c = t; end
        if (a > b) begin t = a; a = b; b = t; end

        // low median goes straight through and cancels fast hold
        if (b <= longint'(filt_cfg.low_threshold)) begin
            level_q16 = b <<< FRAC_SHIFT;
            hold_cnt = '0;
            return b[SAMPLE_W-1:0];
        end

        delta = (b <<< FRAC_SHIFT) - level_q16;
        mag = (delta < 0) ? -delta : delta;
        if (mag >= (longint'(filt_cfg.step_threshold) <<< FRAC_SHIFT))
            hold_cnt = filt_cfg.hold_samples;

        gain = longint'(filt_cfg.normal_gain);
        if (hold_cnt != 0) begin
            gain = longint'(filt_cfg.fast_gain);
            hold_cnt = hold_cnt - 1'b1;
        end

        level_q16 = level_q16 + ((gain * delta) >>> GAIN_SHIFT);
        if (level_q16 < 0)
            level_q16 = 0;
        else if (level_q16 > LEVEL_MAX)
            level_q16 = LEVEL_MAX;

        t = level_q16 >>> FRAC_SHIFT;
        return t[SAMPLE_W-1:0];
    endfunction

    function automatic logic [15:0] pick_setting(input int lo, input int hi, input int usual_hi,
                                                 input int phase);
        int roll;
        roll = $urandom_range(99);
        if (phase == 1 || roll < 15)
            return 16'(lo);
        if (phase == 2 || roll < 30)
            return 16'(hi);
        return 16'($urandom_range(usual_hi, lo));
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                               input logic [SAMPLE_W-1:0] want);
        logic [SAMPLE_W-1:0] predicted;
        if (!quiet_run && $urandom_range(99) < 30) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= TDATA_BITS'(s);
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        predicted = next_filtered(s);
        expected_filtered.push_back(typed ? want : predicted);
    endtask

    // drop valid, drain every pending result, then let the pipeline empty
    task automatic settle_idle();
        i_s_axis_tvalid <= 1'b0;
        while (expected_filtered.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            REG_NORMAL_GAIN:    filt_cfg.normal_gain    = data;
            REG_FAST_GAIN:      filt_cfg.fast_gain      = data;
            REG_STEP_THRESHOLD: filt_cfg.step_threshold = data[14:0];
            REG_LOW_THRESHOLD:  filt_cfg.low_threshold  = data[14:0];
            REG_HOLD_SAMPLES:   filt_cfg.hold_samples   = data;
            default: ;
        endcase
    endtask

    task automatic cfg_close();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    t_stim_row directed_rows [34] = '{
        '{ROW_SAMPLE, REG_NORMAL_GAIN,    16'h7FFF, 1'b1, 16'h7FFF},  // first sample as is
        '{ROW_SAMPLE, REG_NORMAL_GAIN,    16'h7FFF, 1'b1, 16'd25600}, // clamp to full scale
        '{ROW_SAMPLE, REG_NORMAL_GAIN,    16'h8000, 1'b1, 16'd25600},
        '{ROW_SAMPLE, REG_NORMAL_GAIN,    16'h8000, 1'b1, 16'h8000},  // negative passes
        '{ROW_SAMPLE, REG_NORMAL_GAIN,    16'h0000, 1'b1, 16'h8000},
        '{ROW_SAMPLE, REG_NORMAL_GAIN,    16'h0000, 1'b1, 16'h0000},
        '{ROW_SAMPLE, REG_NORMAL_GAIN,    16'd100,  1'b1, 16'h0000},
        '{ROW_SAMPLE, REG_NORMAL_GAIN,    16'd2560, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_NORMAL_GAIN,    16'd2600, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_NORMAL_GAIN,    16'd2650, 1'b0, 16'h0000},
        '{ROW_CFG,    REG_LOW_THRESHOLD,  16'd25600, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_NORMAL_GAIN,    16'd12345, 1'b0, 16'h0000},
        '{ROW_CFG,    REG_STEP_THRESHOLD, 16'd0,    1'b0, 16'h0000},  // every jump holds
        '{ROW_CFG,    REG_HOLD_SAMPLES,   16'd3,    1'b0, 16'h0000},
        '{ROW_CFG,    REG_FAST_GAIN,      16'hFFFF, 1'b0, 16'h0000},
        '{ROW_CFG,    REG_LOW_THRESHOLD,  16'd0,    1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_NORMAL_GAIN,    16'd5000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_NORMAL_GAIN,    16'd5000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_NORMAL_GAIN,    16'd20000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_NORMAL_GAIN,    16'd20000, 1'b0, 16'h0000},
        '{ROW_CFG,    REG_HOLD_SAMPLES,   16'd0,    1'b0, 16'h0000},  // jump loads zero
        '{ROW_CFG,    REG_STEP_THRESHOLD, 16'd1,    1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_NORMAL_GAIN,    16'd3000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_NORMAL_GAIN,    16'd3000, 1'b0, 16'h0000},
        '{ROW_CFG,    REG_SPARE_FIRST,    16'hFFFF, 1'b0, 16'h0000},  // must be ignored
        '{ROW_CFG,    REG_SPARE_LAST,     16'hFFFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_NORMAL_GAIN,    16'd3000, 1'b0, 16'h0000},
        '{ROW_CFG,    REG_NORMAL_GAIN,    16'd0,    1'b0, 16'h0000},  // level frozen
        '{ROW_SAMPLE, REG_NORMAL_GAIN,    16'd9000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_NORMAL_GAIN,    16'd9000, 1'b0, 16'h0000},
        '{ROW_CFG,    REG_NORMAL_GAIN,    16'hFFFF, 1'b0, 16'h0000},
        '{ROW_CFG,    REG_STEP_THRESHOLD, 16'hFFFF, 1'b0, 16'h0000},  // top bit dropped
        '{ROW_SAMPLE, REG_NORMAL_GAIN,    16'd25600, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_NORMAL_GAIN,    16'd25600, 1'b0, 16'h0000}
    };

    // sender: reset, directed table, then phased random traffic
    initial begin
        int trend, roll, raw;
        trend = 2560;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                if (!cfg_open) begin
                    settle_idle();
                    cfg_open = 1'b1;
                end
                cfg_write(directed_rows[i].idx, directed_rows[i].value);
            end else begin
                if (cfg_open) begin
                    cfg_close();
                    cfg_open = 1'b0;
                end
                send_sample(directed_rows[i].value, directed_rows[i].typed,
                            directed_rows[i].want);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            settle_idle();
            cfg_write(REG_NORMAL_GAIN,    pick_setting(0, 65535, 65535, phase));
            cfg_write(REG_FAST_GAIN,      pick_setting(0, 65535, 65535, phase));
            cfg_write(REG_STEP_THRESHOLD, pick_setting(1, 25600, 4000, phase));
            cfg_write(REG_LOW_THRESHOLD,  pick_setting(0, 25600, 2000, phase));
            cfg_write(REG_HOLD_SAMPLES,   pick_setting(0, 65535, 20, phase));
            if ($urandom_range(3) == 0)
                cfg_write(CFG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                          16'($urandom_range(65535)));
            cfg_close();
            quiet_run = (phase == 4);

            repeat (PHASE_LEN) begin
                roll = $urandom_range(99);
                if (roll < 55) begin
                    // slow pressure trend with the odd large step
                    if ($urandom_range(99) < 5)
                        trend = $urandom_range(25600);
                    raw = trend + $urandom_range(200) - 100;
                end else if (roll < 70) begin
                    raw = $urandom_range(32767);              // lone spike
                end else if (roll < 80) begin
                    raw = $urandom_range(65535);              // any bit pattern
                end else if (roll < 90) begin
                    raw = $urandom_range(600) - 300;          // around zero
                end else begin
                    raw = $urandom_range(32767, 25600);       // at or above full scale
                end
                send_sample(16'(raw), 1'b0, '0);
            end
        end

        settle_idle();
        repeat (6) @(posedge i_clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // receiver: check beats, random back-pressure, one long hold-off
    initial begin
        int stall_left;
        bit held_off;
        logic [SAMPLE_W-1:0] want;
        stall_left = 0;
        held_off = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
                if (expected_filtered.size() == 0) begin
                    $display("%0t: result beat with no sample pending, got %0d",
                             $time, $signed(o_m_axis_tdata[SAMPLE_W-1:0]));
                    mismatches++;
                end else begin
                    want = expected_filtered.pop_front();
                    if (o_m_axis_tdata[SAMPLE_W-1:0] !== want) begin
                        $display("%0t: filtered mismatch, expected %0d, got %0d",
                                 $time, $signed(want),
                                 $signed(o_m_axis_tdata[SAMPLE_W-1:0]));
                        mismatches++;
                    end
                end
                results_checked++;
            end
            if (!held_off && results_checked >= 400) begin
                held_off = 1'b1;
                stall_left = 300;
            end
            if (stall_left > 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_axis_tready <= quiet_run || ($urandom_range(99) >= 30);
            end
        end
    end

    // watchdog: end the run if no beat moves on either side for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready === 1'b1) ||
                (o_m_axis_tvalid === 1'b1 && i_m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

endmodule
